// ===== rtl/core/sdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Settle and drop trigger package
// Types, register indexes and the microcode program of the trigger sequencer.
// ----------------------------------------------------------------------------
package sdt_pkg;

   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_DATA_W-1:0] SETTLE_BAND_RESET = 24'd2400;
   localparam logic [CSR_DATA_W-1:0] UNLOAD_DROP_RESET = 24'd11200;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE      = 2'd0,
      CSR_SETTLE_BAND = 2'd1,
      CSR_UNLOAD_DROP = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      STEP_WAIT,
      STEP_CHECK,
      STEP_SCAN,
      STEP_LAST,
      STEP_EVAL,
      STEP_EMIT
   } step_type;

   typedef enum logic [2:0] {
      JC_NEVER,
      JC_ALWAYS,
      JC_NO_ACCEPT,
      JC_SKIP_SCAN,
      JC_SCAN_MORE,
      JC_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic     take_in;
      logic     scan_start;
      logic     scan_step;
      logic     scan_merge;
      logic     evaluate;
      logic     load_out;
      cond_type hold_cond;
      cond_type jump_cond;
      step_type jump_target;
   } ctrl_word_type;

   typedef struct packed {
      logic fire;
      logic fire_kind;
      logic window_full;
      logic is_settled;
   } result_type;

   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type w;
      w = '{take_in: 1'b0, scan_start: 1'b0, scan_step: 1'b0, scan_merge: 1'b0,
            evaluate: 1'b0, load_out: 1'b0, hold_cond: JC_NEVER,
            jump_cond: JC_NEVER, jump_target: STEP_WAIT};
      unique case (step)
         STEP_WAIT: begin
            w.take_in   = 1'b1;
            w.hold_cond = JC_NO_ACCEPT;
         end
         STEP_CHECK: begin
            w.scan_start  = 1'b1;
            w.jump_cond   = JC_SKIP_SCAN;
            w.jump_target = STEP_EMIT;
         end
         STEP_SCAN: begin
            w.scan_step = 1'b1;
            w.hold_cond = JC_SCAN_MORE;
         end
         STEP_LAST: begin
            w.scan_merge = 1'b1;
         end
         STEP_EVAL: begin
            w.evaluate = 1'b1;
         end
         STEP_EMIT: begin
            w.load_out    = 1'b1;
            w.hold_cond   = JC_OUT_BUSY;
            w.jump_cond   = JC_ALWAYS;
            w.jump_target = STEP_WAIT;
         end
         default: begin
            w.jump_cond   = JC_ALWAYS;
            w.jump_target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/sdt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 15
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/settle_and_drop_trigger.sv =====
// ----------------------------------------------------------------------------
// Settle and drop trigger
// An accepted transaction goes from the check step to the emit step, by way of
// a window scan and the last and eval steps when the window is full and the
// block enabled. A new transaction is taken only in the wait step, after the
// emit step; the window RAM is read one entry a cycle through its single read
// port. A result still stalled at the output holds the emit step.
// Synchronous reset clears fill count, peak, baseline flag and registers; window
// contents are undefined until written.
// ----------------------------------------------------------------------------
module settle_and_drop_trigger #(
   parameter int WINDOW_LEN   = 15,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [SAMPLE_WIDTH-1:0]        req_level_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_fire,
   output logic                           rsp_fire_kind,
   output logic                           rsp_window_full,
   output logic                           rsp_is_settled,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sdt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sdt_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = $clog2(WINDOW_LEN);
   localparam int FW = $clog2(WINDOW_LEN + 1);
   localparam int CW = (SAMPLE_WIDTH > sdt_pkg::CSR_DATA_W) ? SAMPLE_WIDTH
                                                            : sdt_pkg::CSR_DATA_W;

   sdt_pkg::step_type      step_ff, step_in;
   sdt_pkg::ctrl_word_type ctrl;
   sdt_pkg::result_type    res_ff, res_in;
   sdt_pkg::result_type    rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic [SAMPLE_WIDTH-1:0] peak_ff, peak_in;
   logic [SAMPLE_WIDTH-1:0] lo_ff, lo_in;
   logic [SAMPLE_WIDTH-1:0] hi_ff, hi_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic [AW-1:0]           wpos_ff, wpos_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic                    base_ff, base_in;

   logic                            enable_ff;
   logic [sdt_pkg::CSR_DATA_W-1:0]  band_ff;
   logic [sdt_pkg::CSR_DATA_W-1:0]  drop_ff;

   logic                    accept;
   logic                    out_busy;
   logic                    skip_scan;
   logic                    scan_more;
   logic                    hold_true;
   logic                    jump_true;
   logic [SAMPLE_WIDTH-1:0] rd_data;
   logic [SAMPLE_WIDTH-1:0] spread;
   logic [SAMPLE_WIDTH-1:0] drop_amt;
   logic                    settled;
   logic                    unloaded;
   logic                    fire;

   function automatic logic cond_eval(input sdt_pkg::cond_type c, input logic acc,
                                      input logic skip, input logic more,
                                      input logic busy);
      logic r;
      r = 1'b0;
      unique case (c)
         sdt_pkg::JC_NEVER:     r = 1'b0;
         sdt_pkg::JC_ALWAYS:    r = 1'b1;
         sdt_pkg::JC_NO_ACCEPT: r = !acc;
         sdt_pkg::JC_SKIP_SCAN: r = skip;
         sdt_pkg::JC_SCAN_MORE: r = more;
         sdt_pkg::JC_OUT_BUSY:  r = busy;
         default:               r = 1'b0;
      endcase
      return r;
   endfunction

   sdt_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (WINDOW_LEN)
   ) u_window (
      .clock   (clock),
      .wr_en   (accept && enable_ff),
      .wr_addr (wpos_ff),
      .wr_data (req_level_sample),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign ctrl      = sdt_pkg::ucode(step_ff);
   assign req_stall = !ctrl.take_in;
   assign accept    = req_valid && ctrl.take_in;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign skip_scan = !enable_ff || (fill_ff != FW'(WINDOW_LEN));
   assign scan_more = (idx_ff != AW'(WINDOW_LEN - 1));
   assign hold_true = cond_eval(ctrl.hold_cond, accept, skip_scan, scan_more, out_busy);
   assign jump_true = cond_eval(ctrl.jump_cond, accept, skip_scan, scan_more, out_busy);

   assign spread   = hi_ff - lo_ff;
   assign drop_amt = peak_ff - sample_ff;
   assign settled  = CW'(spread) <= CW'(band_ff);
   assign unloaded = (peak_ff >= sample_ff) && (CW'(drop_amt) >= CW'(drop_ff));
   assign fire     = settled && (!base_ff || unloaded);

   always_comb begin
      step_in      = step_ff;
      sample_in    = sample_ff;
      peak_in      = peak_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      fill_in      = fill_ff;
      wpos_in      = wpos_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (hold_true) begin
         step_in = step_ff;
      end else if (jump_true) begin
         step_in = ctrl.jump_target;
      end else begin
         step_in = sdt_pkg::step_type'(step_ff + 3'd1);
      end

      if (accept) begin
         sample_in = req_level_sample;
         if (enable_ff) begin
            wpos_in = (wpos_ff == AW'(WINDOW_LEN - 1)) ? '0 : wpos_ff + AW'(1);
            if (fill_ff != FW'(WINDOW_LEN)) begin
               fill_in = fill_ff + FW'(1);
            end
            if (req_level_sample > peak_ff) begin
               peak_in = req_level_sample;
            end
         end
      end

      if (ctrl.scan_start) begin
         idx_in = '0;
         res_in = '0;
      end

      if (ctrl.scan_step) begin
         if (scan_more) begin
            idx_in = idx_ff + AW'(1);
         end
         if (idx_ff == AW'(1)) begin
            lo_in = rd_data;
            hi_in = rd_data;
         end else if (idx_ff != '0) begin
            lo_in = (rd_data < lo_ff) ? rd_data : lo_ff;
            hi_in = (rd_data > hi_ff) ? rd_data : hi_ff;
         end
      end

      if (ctrl.scan_merge) begin
         lo_in = (rd_data < lo_ff) ? rd_data : lo_ff;
         hi_in = (rd_data > hi_ff) ? rd_data : hi_ff;
      end

      if (ctrl.evaluate) begin
         res_in.fire        = fire;
         res_in.fire_kind   = fire && base_ff;
         res_in.window_full = 1'b1;
         res_in.is_settled  = settled;
         if (fire) begin
            base_in = 1'b1;
            fill_in = '0;
            wpos_in = '0;
            peak_in = sample_ff;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.load_out && !out_busy) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= sdt_pkg::STEP_WAIT;
         peak_ff      <= '0;
         fill_ff      <= '0;
         wpos_ff      <= '0;
         idx_ff       <= '0;
         base_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         peak_ff      <= peak_in;
         fill_ff      <= fill_in;
         wpos_ff      <= wpos_in;
         idx_ff       <= idx_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         band_ff   <= sdt_pkg::SETTLE_BAND_RESET;
         drop_ff   <= sdt_pkg::UNLOAD_DROP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sdt_pkg::CSR_ENABLE:      enable_ff <= csr_data[0];
            sdt_pkg::CSR_SETTLE_BAND: band_ff   <= csr_data;
            sdt_pkg::CSR_UNLOAD_DROP: drop_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fire        = rsp_data_ff.fire;
   assign rsp_fire_kind   = rsp_data_ff.fire_kind;
   assign rsp_window_full = rsp_data_ff.window_full;
   assign rsp_is_settled  = rsp_data_ff.is_settled;

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (step_ff == sdt_pkg::STEP_CHECK))
      else $error("Accepted transaction did not advance to the check step.");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step_ff == sdt_pkg::STEP_EMIT))
      else $error("Result appeared outside the emit step.");

   a_fire_needs_settled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fire) |-> (rsp_is_settled && rsp_window_full))
      else $error("Fire reported on an unsettled or partial window.");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(WINDOW_LEN))
      else $error("Fill count exceeds the window length.");

endmodule

// ===== dv/settle_and_drop_trigger_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Settle and drop trigger checker
// Watches the register, sample and result channels of the trigger, predicts
// the result of every accepted sample transaction from its own copy of the
// window, peak, baseline flag and registers, and compares each accepted result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module settle_and_drop_trigger_checker #(
   parameter int WINDOW_LEN   = 15,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [SAMPLE_WIDTH-1:0]         req_level_sample,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_fire,
   input  logic                            rsp_fire_kind,
   input  logic                            rsp_window_full,
   input  logic                            rsp_is_settled,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [sdt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sdt_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              fail_count,
   output int                              pending
);

   localparam int EXP_DEPTH = 8;

   logic [SAMPLE_WIDTH-1:0] level_window [WINDOW_LEN];
   int                      level_count;
   int                      write_slot;
   logic [SAMPLE_WIDTH-1:0] peak_seen;
   logic                    baseline_seen;

   logic                          trig_enable;
   logic [sdt_pkg::CSR_DATA_W-1:0] band_limit;
   logic [sdt_pkg::CSR_DATA_W-1:0] drop_limit;

   sdt_pkg::result_type expected_triggers [EXP_DEPTH];
   int                  exp_head;
   int                  exp_tail;
   int                  exp_count;

   function automatic sdt_pkg::result_type predict_trigger(input logic [SAMPLE_WIDTH-1:0] s);
      sdt_pkg::result_type     r;
      logic [SAMPLE_WIDTH-1:0] lo;
      logic [SAMPLE_WIDTH-1:0] hi;
      logic                    settled;
      logic                    unloaded;
      int                      i;
      r = '0;
      if (!trig_enable) begin
         return r;
      end
      level_window[write_slot] = s;
      write_slot = (write_slot == WINDOW_LEN - 1) ? 0 : write_slot + 1;
      if (level_count < WINDOW_LEN) begin
         level_count++;
      end
      if (s > peak_seen) begin
         peak_seen = s;
      end
      if (level_count < WINDOW_LEN) begin
         return r;
      end
      lo = level_window[0];
      hi = level_window[0];
      for (i = 1; i < WINDOW_LEN; i++) begin
         if (level_window[i] < lo) lo = level_window[i];
         if (level_window[i] > hi) hi = level_window[i];
      end
      settled  = (hi - lo) <= band_limit;
      unloaded = (peak_seen >= s) && ((peak_seen - s) >= drop_limit);
      r.window_full = 1'b1;
      r.is_settled  = settled;
      r.fire        = settled && (!baseline_seen || unloaded);
      r.fire_kind   = r.fire && baseline_seen;
      if (r.fire) begin
         baseline_seen = 1'b1;
         level_count   = 0;
         write_slot    = 0;
         peak_seen     = s;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      sdt_pkg::result_type want;
      sdt_pkg::result_type next_pred;
      if (reset) begin
         level_count   = 0;
         write_slot    = 0;
         peak_seen     = '0;
         baseline_seen = 1'b0;
         trig_enable   = 1'b0;
         band_limit    = sdt_pkg::SETTLE_BAND_RESET;
         drop_limit    = sdt_pkg::UNLOAD_DROP_RESET;
         exp_head      = 0;
         exp_tail      = 0;
         exp_count     = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sdt_pkg::CSR_ENABLE:      trig_enable = csr_data[0];
               sdt_pkg::CSR_SETTLE_BAND: band_limit  = csr_data;
               sdt_pkg::CSR_UNLOAD_DROP: drop_limit  = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (exp_count == 0) begin
               $error("Result transaction arrived with no prediction waiting.");
               fail_count++;
            end else begin
               want      = expected_triggers[exp_head];
               exp_head  = (exp_head == EXP_DEPTH - 1) ? 0 : exp_head + 1;
               exp_count--;
               if (rsp_fire !== want.fire) begin
                  $error("fire: expected %0d, got %0d", want.fire, rsp_fire);
                  fail_count++;
               end
               if (rsp_fire_kind !== want.fire_kind) begin
                  $error("fire_kind: expected %0d, got %0d", want.fire_kind, rsp_fire_kind);
                  fail_count++;
               end
               if (rsp_window_full !== want.window_full) begin
                  $error("window_full: expected %0d, got %0d",
                         want.window_full, rsp_window_full);
                  fail_count++;
               end
               if (rsp_is_settled !== want.is_settled) begin
                  $error("is_settled: expected %0d, got %0d", want.is_settled, rsp_is_settled);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            next_pred = predict_trigger(req_level_sample);
            if (exp_count == EXP_DEPTH) begin
               $error("More sample transactions in flight than the block can hold.");
               fail_count++;
            end else begin
               expected_triggers[exp_tail] = next_pred;
               exp_tail  = (exp_tail == EXP_DEPTH - 1) ? 0 : exp_tail + 1;
               exp_count++;
            end
         end
      end
      pending = exp_count;
   end

endmodule

// ===== dv/settle_and_drop_trigger_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Settle and drop trigger testbench
// Drives level samples and register writes into the trigger through several
// band and drop settings, mixing settled plateaus, unload sequences, broken
// plateaus and noise, with random sample idling and result back pressure.
// The checker predicts and compares; this module only makes stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module settle_and_drop_trigger_tb;

   localparam int  WINDOW_LEN   = 15;
   localparam int  SAMPLE_WIDTH = 24;
   localparam int  CYCLE_LIMIT  = 400000;
   localparam logic [SAMPLE_WIDTH-1:0] LEVEL_MAX = 24'hFFFFFF;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [SAMPLE_WIDTH-1:0]         req_level_sample = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_fire;
   logic                            rsp_fire_kind;
   logic                            rsp_window_full;
   logic                            rsp_is_settled;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [sdt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sdt_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int samples_sent = 0;
   int hold_left = 0;
   int burst_left = 0;
   bit idle_on = 1'b1;
   logic [SAMPLE_WIDTH-1:0] cur_band;
   logic [SAMPLE_WIDTH-1:0] cur_drop;

   always #10 clock = ~clock;

   settle_and_drop_trigger dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_level_sample (req_level_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fire         (rsp_fire),
      .rsp_fire_kind    (rsp_fire_kind),
      .rsp_window_full  (rsp_window_full),
      .rsp_is_settled   (rsp_is_settled),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   settle_and_drop_trigger_checker #(
      .WINDOW_LEN   (WINDOW_LEN),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_level_sample (req_level_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fire         (rsp_fire),
      .rsp_fire_kind    (rsp_fire_kind),
      .rsp_window_full  (rsp_window_full),
      .rsp_is_settled   (rsp_is_settled),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // The result side stalls in short random bursts, or for a long stretch
   // when the stimulus asks for one.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left == 0 && burst_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(1, 3);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (burst_left > 0) begin
            rsp_stall <= 1'b1;
            burst_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [SAMPLE_WIDTH-1:0] clip_level(input longint v);
      if (v < 0) return '0;
      if (v > longint'(LEVEL_MAX)) return LEVEL_MAX;
      return v[SAMPLE_WIDTH-1:0];
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] pick_spread();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return cur_band;
         2: return SAMPLE_WIDTH'($urandom_range(0, cur_band));
         default: return clip_level(longint'(cur_band) + $urandom_range(1, 3000));
      endcase
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] pick_offset(input logic [SAMPLE_WIDTH-1:0] spread);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return spread;
         default: return SAMPLE_WIDTH'($urandom_range(0, spread));
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high.
   task automatic send_level(input logic [SAMPLE_WIDTH-1:0] s);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_level_sample <= s;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input sdt_pkg::csr_index_type idx,
                            input logic [sdt_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic en, input logic [SAMPLE_WIDTH-1:0] band,
                            input logic [SAMPLE_WIDTH-1:0] drop);
      wait_drained();
      repeat (4) @(negedge clock);
      cur_band = band;
      cur_drop = drop;
      csr_write(sdt_pkg::CSR_SETTLE_BAND, band);
      csr_write(sdt_pkg::CSR_UNLOAD_DROP, drop);
      csr_write(sdt_pkg::CSR_ENABLE, {23'd0, en});
   endtask

   task automatic send_plateau(input logic [SAMPLE_WIDTH-1:0] base,
                               input logic [SAMPLE_WIDTH-1:0] spread, input int len);
      repeat (len) send_level(clip_level(longint'(base) + pick_offset(spread)));
   endtask

   // A short spike sets the peak, then a low plateau, usually settled, sits at or
   // below the peak minus the unload drop.
   task automatic send_unload();
      logic [SAMPLE_WIDTH-1:0] peak;
      logic [SAMPLE_WIDTH-1:0] low;
      logic [SAMPLE_WIDTH-1:0] spread;
      int                      extra;
      peak = SAMPLE_WIDTH'($urandom_range(cur_drop, LEVEL_MAX));
      repeat ($urandom_range(1, 3)) send_level(peak);
      extra = 0;
      if ($urandom_range(0, 1) == 0) begin
         extra = $urandom_range(0, (peak - cur_drop > 4000) ? 4000 : peak - cur_drop);
      end
      low    = peak - cur_drop - SAMPLE_WIDTH'(extra);
      spread = ($urandom_range(0, 3) == 0) ? pick_spread()
                                            : SAMPLE_WIDTH'($urandom_range(0, cur_band));
      repeat ($urandom_range(15, 18)) begin
         send_level(clip_level(longint'(low) - pick_offset(spread)));
      end
   endtask

   task automatic run_random(input int count);
      int stop_at;
      stop_at = samples_sent + count;
      while (samples_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_plateau(SAMPLE_WIDTH'($urandom_range(0, LEVEL_MAX)),
                                     pick_spread(), $urandom_range(15, 19));
            4, 5, 6: send_unload();
            7: repeat ($urandom_range(1, 4)) begin
               send_level(SAMPLE_WIDTH'($urandom_range(0, LEVEL_MAX)));
            end
            8: send_plateau(($urandom_range(0, 1) == 0) ? '0 : LEVEL_MAX - cur_band,
                            pick_spread(), $urandom_range(15, 17));
            default: send_plateau(SAMPLE_WIDTH'($urandom_range(0, LEVEL_MAX)),
                                  pick_spread(), $urandom_range(2, 14));
         endcase
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      cur_band = sdt_pkg::SETTLE_BAND_RESET;
      cur_drop = sdt_pkg::UNLOAD_DROP_RESET;

      // Disabled after reset: extremes of the sample give all-zero results.
      send_level('0);
      send_level(LEVEL_MAX);
      wait_drained();
      csr_write(sdt_pkg::CSR_ENABLE, 24'd1);

      // Fill the window with a spread exactly at the band: start event.
      repeat (WINDOW_LEN - 1) send_level(24'd1000);
      send_level(24'd3400);
      send_level(24'd5);

      configure(1'b1, sdt_pkg::SETTLE_BAND_RESET, sdt_pkg::UNLOAD_DROP_RESET);
      run_random(150);
      hold_left = 300;
      run_random(150);
      wait_drained();
      run_random(100);

      configure(1'b1, '0, '0);
      run_random(150);

      configure(1'b1, LEVEL_MAX, LEVEL_MAX);
      run_random(200);

      configure(1'b0, SAMPLE_WIDTH'($urandom_range(0, 8000)),
                SAMPLE_WIDTH'($urandom_range(0, 40000)));
      run_random(40);

      configure(1'b1, SAMPLE_WIDTH'($urandom_range(0, 8000)),
                SAMPLE_WIDTH'($urandom_range(0, 40000)));
      run_random(200);

      configure(1'b1, 24'd2400, '0);
      run_random(150);

      idle_on = 1'b0;
      configure(1'b1, sdt_pkg::SETTLE_BAND_RESET, sdt_pkg::UNLOAD_DROP_RESET);
      run_random(150);

      wait_drained();
      repeat (3 * (WINDOW_LEN + 5)) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
